// ===== hdl/ktdc_pkg.sv =====
`default_nettype none

package ktdc_pkg;

    localparam int KTDC_KEY_DEPTH = 4096;

    // Input item kinds
    localparam logic [1:0] MODE_KEY  = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    // Configuration register indexes
    localparam logic REG_DECRYPT_MODE = 1'b0;
    localparam logic REG_KEY_LENGTH   = 1'b1;

    localparam int CFG_DATA_W = 13;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QUERY = 8'h3F;

    localparam logic [6:0] ENC_LINE_LEN = 7'd72;
    localparam logic [6:0] DEC_LINE_MIN = 7'd60;
    localparam logic [6:0] LINE_MAX     = 7'd127;

    typedef logic [7:0] byte_t;

endpackage : ktdc_pkg

`default_nettype wire

// ===== hdl/ktdc_ram.sv =====
`default_nettype none

module ktdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule : ktdc_ram

`default_nettype wire

// ===== hdl/key_text_digraph_cipher.sv =====
// A key write goes straight into the key RAM; a data item scans the key store at one
// byte per cycle, then emits its results. Dropped and held bytes produce no result.
// Flow: one item at a time; s_ready is high only while the block is idle.
// Reset: synchronous, active low; clears mode, line count and the held byte, and sets
// key length to 3 and key position to 2. The key store is undefined until written.
`default_nettype none

module key_text_digraph_cipher
    import ktdc_pkg::*;
#(
    parameter int KEY_DEPTH = KTDC_KEY_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_mode,
    input  wire logic [11:0]           s_key_address,
    input  wire logic [7:0]            s_data_byte,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [7:0]            m_out_byte,
    output logic                       m_last
);

    localparam int AW = $clog2(KEY_DEPTH);
    localparam int LW = $clog2(KEY_DEPTH + 1);
    localparam logic [AW-1:0] POS0 = AW'(0);
    localparam logic [AW-1:0] POS1 = AW'(1);
    localparam logic [AW-1:0] POS2 = AW'(2);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_E1   = 4'd1;
    localparam logic [3:0] ST_E2   = 4'd2;
    localparam logic [3:0] ST_ERA  = 4'd3;
    localparam logic [3:0] ST_ERB  = 4'd4;
    localparam logic [3:0] ST_ERC  = 4'd5;
    localparam logic [3:0] ST_D1   = 4'd6;
    localparam logic [3:0] ST_D2   = 4'd7;
    localparam logic [3:0] ST_DRA  = 4'd8;
    localparam logic [3:0] ST_DRB  = 4'd9;
    localparam logic [3:0] ST_EMIT = 4'd10;

    // control state
    logic [3:0]            st_reg, st_next;
    logic                  dec_reg, dec_next;
    logic [CFG_DATA_W-1:0] klen_reg, klen_next;
    logic [AW-1:0]         kp_reg, kp_next;
    logic [6:0]            lc_reg, lc_next;
    logic                  pendv_reg, pendv_next;
    logic                  issue_reg, issue_next;
    logic                  rdv_reg, rdv_next;
    logic                  prevv_reg, prevv_next;
    logic                  k2v_reg, k2v_next;
    logic [1:0]            ocnt_reg, ocnt_next;
    logic [1:0]            oidx_reg, oidx_next;

    // payload state
    byte_t                 pend_reg, pend_next;
    byte_t                 cur_reg, cur_next;
    byte_t                 key2_reg, key2_next;
    byte_t                 prev_reg, prev_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [AW-1:0]         end_reg, end_next;
    logic [AW-1:0]         rdpos_reg, rdpos_next;
    logic [AW-1:0]         p_reg, p_next;
    logic [AW-1:0]         k2pos_reg, k2pos_next;
    byte_t                 ob_reg [3];
    byte_t                 ob_next [3];

    // key RAM port
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    byte_t                 ram_rdata;

    // helpers
    logic [LW-1:0]         len_w;
    logic [AW-1:0]         last_a;
    logic                  kp_in;
    logic [AW-1:0]         e_start;
    logic                  e_start_in;
    logic [AW-1:0]         e_wend;
    logic                  e_wrap_ok;
    logic [AW-1:0]         d_wend;
    logic                  seg_end;
    logic                  e_hit;
    logic                  d_hit;
    logic                  k2_hit;
    logic                  accept;
    logic                  key_in_range;
    logic                  data_drop;
    byte_t                 d_raw;
    byte_t                 dec_o;
    logic [6:0]            dec_lc;
    logic                  dec_nl;
    logic [6:0]            enc_lc;

    ktdc_ram #(
        .WIDTH (8),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_data_byte),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (klen_reg < CFG_DATA_W'(3)) begin
            len_w = LW'(3);
        end else if (32'(klen_reg) > 32'(KEY_DEPTH)) begin
            len_w = LW'(KEY_DEPTH);
        end else begin
            len_w = LW'(klen_reg);
        end
    end

    assign last_a     = AW'(len_w - LW'(1));
    assign kp_in      = LW'(kp_reg) < len_w;
    assign e_start    = (kp_reg < POS2) ? POS2 : kp_reg;
    assign e_start_in = LW'(e_start) < len_w;
    assign e_wend     = e_start_in ? (e_start - POS1) : last_a;
    assign e_wrap_ok  = e_wend >= POS2;
    assign d_wend     = kp_in ? kp_reg : last_a;

    assign seg_end = rdv_reg && (rdpos_reg == end_reg);
    assign e_hit   = rdv_reg && (ram_rdata == cur_reg);
    assign k2_hit  = rdv_reg && (ram_rdata == key2_reg);
    assign d_hit   = rdv_reg && prevv_reg && (prev_reg == pend_reg) && (ram_rdata == cur_reg);

    assign s_ready      = (st_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign key_in_range = 32'(s_key_address) < 32'(KEY_DEPTH);
    assign data_drop    = (s_data_byte == CHAR_NL) || (s_data_byte == CHAR_NUL);

    assign ram_we = accept && (s_mode == MODE_KEY) && key_in_range;

    always_comb begin
        unique case (st_reg)
            ST_IDLE: ram_addr = AW'(s_key_address);
            ST_ERA:  ram_addr = p_reg - POS2;
            ST_ERB:  ram_addr = p_reg - POS1;
            ST_DRA:  ram_addr = p_reg + POS1;
            default: ram_addr = addr_reg;
        endcase
    end

    // decrypt result: found pair in ST_DRB, otherwise '?'
    always_comb begin
        d_raw = (p_reg == last_a) ? CHAR_NUL : ram_rdata;
        if (st_reg == ST_DRB) begin
            dec_o = (d_raw == key2_reg) ? CHAR_SPACE : d_raw;
        end else begin
            dec_o = CHAR_QUERY;
        end
        dec_lc = (lc_reg == LINE_MAX) ? LINE_MAX : lc_reg + 7'd1;
        dec_nl = (dec_lc >= DEC_LINE_MIN) && ((dec_o == CHAR_SPACE) || (dec_o == CHAR_QUERY));
        enc_lc = lc_reg + 7'd2;
    end

    always_comb begin
        st_next    = st_reg;
        dec_next   = dec_reg;
        klen_next  = klen_reg;
        kp_next    = kp_reg;
        lc_next    = lc_reg;
        pendv_next = pendv_reg;
        prevv_next = prevv_reg;
        k2v_next   = k2v_reg;
        ocnt_next  = ocnt_reg;
        oidx_next  = oidx_reg;
        pend_next  = pend_reg;
        cur_next   = cur_reg;
        key2_next  = key2_reg;
        prev_next  = prev_reg;
        addr_next  = addr_reg;
        end_next   = end_reg;
        p_next     = p_reg;
        k2pos_next = k2pos_reg;
        ob_next    = ob_reg;

        // stream one read per cycle while a segment is open
        rdv_next   = issue_reg;
        rdpos_next = addr_reg;
        issue_next = issue_reg && (addr_reg != end_reg);
        if (issue_reg && (addr_reg != end_reg)) begin
            addr_next = addr_reg + POS1;
        end

        unique case (st_reg)
            ST_IDLE: begin
                rdv_next   = 1'b0;
                issue_next = 1'b0;
                if (ram_we && (AW'(s_key_address) == POS2)) begin
                    key2_next = s_data_byte;
                end
                if (accept) begin
                    priority if (s_mode == MODE_END) begin
                        ob_next[0] = CHAR_NL;
                        ocnt_next  = 2'd1;
                        oidx_next  = 2'd0;
                        kp_next    = dec_reg ? POS0 : POS2;
                        lc_next    = 7'd0;
                        pendv_next = 1'b0;
                        st_next    = ST_EMIT;
                    end else if ((s_mode == MODE_DATA) && !data_drop) begin
                        cur_next = s_data_byte;
                        if (!dec_reg) begin
                            k2v_next   = 1'b0;
                            issue_next = 1'b1;
                            end_next   = last_a;
                            if (e_start_in) begin
                                addr_next = e_start;
                                st_next   = ST_E1;
                            end else begin
                                addr_next = POS2;
                                st_next   = ST_E2;
                            end
                        end else if (!pendv_reg) begin
                            pend_next  = s_data_byte;
                            pendv_next = 1'b1;
                        end else begin
                            pendv_next = 1'b0;
                            prevv_next = 1'b0;
                            issue_next = 1'b1;
                            if (kp_in) begin
                                addr_next = kp_reg;
                                end_next  = last_a;
                                st_next   = ST_D1;
                            end else begin
                                addr_next = POS0;
                                end_next  = d_wend;
                                st_next   = ST_D2;
                            end
                        end
                    end else begin
                        // key writes, dropped bytes and unknown kinds stay idle
                    end
                end
            end

            ST_E1: begin
                if (k2_hit && !k2v_reg) begin
                    k2v_next   = 1'b1;
                    k2pos_next = rdpos_reg;
                end
                priority if (e_hit) begin
                    p_next     = rdpos_reg;
                    rdv_next   = 1'b0;
                    issue_next = 1'b0;
                    st_next    = ST_ERA;
                end else if (seg_end) begin
                    rdv_next = 1'b0;
                    if (e_wrap_ok) begin
                        addr_next  = POS2;
                        end_next   = e_wend;
                        issue_next = 1'b1;
                        st_next    = ST_E2;
                    end else begin
                        issue_next = 1'b0;
                        p_next     = k2v_reg ? k2pos_reg : (k2_hit ? rdpos_reg : POS2);
                        st_next    = ST_ERA;
                    end
                end else begin
                    // keep scanning
                end
            end

            ST_E2: begin
                priority if (e_hit) begin
                    p_next     = rdpos_reg;
                    rdv_next   = 1'b0;
                    issue_next = 1'b0;
                    st_next    = ST_ERA;
                end else if (seg_end) begin
                    // absent from the key: fall back on the space stand-in
                    p_next     = k2v_reg ? k2pos_reg : POS2;
                    rdv_next   = 1'b0;
                    issue_next = 1'b0;
                    st_next    = ST_ERA;
                end else begin
                    // keep scanning
                end
            end

            ST_ERA: begin
                st_next = ST_ERB;
            end

            ST_ERB: begin
                ob_next[0] = ram_rdata;
                st_next    = ST_ERC;
            end

            ST_ERC: begin
                ob_next[1] = ram_rdata;
                oidx_next  = 2'd0;
                if (enc_lc >= ENC_LINE_LEN) begin
                    ob_next[2] = CHAR_NL;
                    ocnt_next  = 2'd3;
                    lc_next    = 7'd0;
                end else begin
                    ocnt_next = 2'd2;
                    lc_next   = enc_lc;
                end
                kp_next = (LW'(p_reg) + LW'(1) >= len_w) ? POS2 : p_reg + POS1;
                st_next = ST_EMIT;
            end

            ST_D1: begin
                if (rdv_reg) begin
                    prev_next  = ram_rdata;
                    prevv_next = 1'b1;
                end
                priority if (d_hit) begin
                    p_next     = rdpos_reg;
                    rdv_next   = 1'b0;
                    issue_next = 1'b0;
                    st_next    = ST_DRA;
                end else if (seg_end) begin
                    // wrap to the start of the key
                    rdv_next   = 1'b0;
                    prevv_next = 1'b0;
                    addr_next  = POS0;
                    end_next   = d_wend;
                    issue_next = 1'b1;
                    st_next    = ST_D2;
                end else begin
                    // keep scanning
                end
            end

            ST_D2: begin
                if (rdv_reg) begin
                    prev_next  = ram_rdata;
                    prevv_next = 1'b1;
                end
                priority if (d_hit) begin
                    p_next     = rdpos_reg;
                    rdv_next   = 1'b0;
                    issue_next = 1'b0;
                    st_next    = ST_DRA;
                end else if (seg_end) begin
                    rdv_next   = 1'b0;
                    issue_next = 1'b0;
                    ob_next[0] = dec_o;
                    oidx_next  = 2'd0;
                    if (dec_nl) begin
                        ob_next[1] = CHAR_NL;
                        ocnt_next  = 2'd2;
                        lc_next    = 7'd0;
                    end else begin
                        ocnt_next = 2'd1;
                        lc_next   = dec_lc;
                    end
                    if (!kp_in) begin
                        kp_next = POS0;
                    end
                    st_next = ST_EMIT;
                end else begin
                    // keep scanning
                end
            end

            ST_DRA: begin
                st_next = ST_DRB;
            end

            ST_DRB: begin
                ob_next[0] = dec_o;
                oidx_next  = 2'd0;
                if (dec_nl) begin
                    ob_next[1] = CHAR_NL;
                    ocnt_next  = 2'd2;
                    lc_next    = 7'd0;
                end else begin
                    ocnt_next = 2'd1;
                    lc_next   = dec_lc;
                end
                kp_next = (p_reg == last_a) ? POS0 : p_reg + POS1;
                st_next = ST_EMIT;
            end

            ST_EMIT: begin
                rdv_next   = 1'b0;
                issue_next = 1'b0;
                if (m_ready) begin
                    if (oidx_reg == ocnt_reg - 2'd1) begin
                        st_next = ST_IDLE;
                    end else begin
                        oidx_next = oidx_reg + 2'd1;
                    end
                end
            end

            default: begin
                rdv_next   = 1'b0;
                issue_next = 1'b0;
                st_next    = ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            unique case (cfg_index)
                REG_DECRYPT_MODE: begin
                    dec_next   = cfg_wdata[0];
                    kp_next    = cfg_wdata[0] ? POS0 : POS2;
                    lc_next    = 7'd0;
                    pendv_next = 1'b0;
                end
                REG_KEY_LENGTH: begin
                    klen_next = cfg_wdata;
                end
                default: begin
                    klen_next = klen_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            dec_reg   <= 1'b0;
            klen_reg  <= CFG_DATA_W'(3);
            kp_reg    <= POS2;
            lc_reg    <= 7'd0;
            pendv_reg <= 1'b0;
            issue_reg <= 1'b0;
            rdv_reg   <= 1'b0;
            prevv_reg <= 1'b0;
            k2v_reg   <= 1'b0;
            ocnt_reg  <= 2'd1;
            oidx_reg  <= 2'd0;
        end else begin
            st_reg    <= st_next;
            dec_reg   <= dec_next;
            klen_reg  <= klen_next;
            kp_reg    <= kp_next;
            lc_reg    <= lc_next;
            pendv_reg <= pendv_next;
            issue_reg <= issue_next;
            rdv_reg   <= rdv_next;
            prevv_reg <= prevv_next;
            k2v_reg   <= k2v_next;
            ocnt_reg  <= ocnt_next;
            oidx_reg  <= oidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg  <= pend_next;
        cur_reg   <= cur_next;
        key2_reg  <= key2_next;
        prev_reg  <= prev_next;
        addr_reg  <= addr_next;
        end_reg   <= end_next;
        rdpos_reg <= rdpos_next;
        p_reg     <= p_next;
        k2pos_reg <= k2pos_next;
        ob_reg    <= ob_next;
    end

    assign m_valid    = (st_reg == ST_EMIT);
    assign m_out_byte = ob_reg[oidx_reg];
    assign m_last     = (oidx_reg == ocnt_reg - 2'd1);

`ifndef SYNTH
    a_no_overlap : assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while results are pending");

    a_emit_index : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (oidx_reg < ocnt_reg))
        else $error("result index beyond result count");

    a_last_frees : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("block not ready after final result");

    a_read_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        rdv_reg |-> (rdpos_reg <= end_reg))
        else $error("scan read beyond segment end");
`endif

endmodule : key_text_digraph_cipher

`default_nettype wire
